FILE: sv/cwac_pkg.sv
// Shared types, codes and map decoding for the Chinese-wall access checker.
// Used by cwac_decide and chinese_wall_access_checker_unit; no dependencies.
`default_nettype none

package cwac_pkg;

  localparam int unsigned DEF_NUM_SUBJECTS = 16;
  localparam int unsigned DEF_NUM_OBJECTS  = 8;
  localparam int unsigned DEF_NUM_FIRMS    = 8;
  localparam int unsigned DEF_NUM_CLASSES  = 8;

  localparam int unsigned MAP_W     = 32;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned SUBJ_W    = 4;
  localparam int unsigned OBJ_W     = 3;
  localparam int unsigned OUTCOME_W = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned BITMAP_W  = 9;

  typedef logic [3:0]          code_t;
  typedef logic [BITMAP_W-1:0] bitmap_t;

  // The "no firm" and "no class" code; it is also the extra bitmap bit.
  localparam code_t NONE_CODE = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_REFUSED  = 2'd0,
    OUT_ACCEPTED = 2'd1,
    OUT_CLEARED  = 2'd2
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OBJECT_FIRM_MAP = 1'd0,
    REG_FIRM_CLASS_MAP  = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    bitmap_t acc;
    bitmap_t rd;
  } hist_t;

  typedef struct packed {
    logic     wr;
    logic     clear;
    hist_t    hist;
    outcome_t outcome;
  } decision_t;

  // Picks the 4-bit code of entry idx from a map; codes at or above limit mean none.
  function automatic code_t map_code(logic [MAP_W-1:0] map, logic [2:0] idx,
                                     int unsigned limit);
    code_t c;
    c = map[{idx, 2'b00} +: 4];
    return (32'(c) < limit) ? c : NONE_CODE;
  endfunction

endpackage

`default_nettype wire

FILE: sv/chinese_wall_access_checker_unit.sv
// Brewer-Nash (Chinese wall) access checker, top level.
// Depends on cwac_pkg and cwac_decide.
`default_nettype none

// The block takes one request beat per clock unless out_ready stalls it, and
// returns one outcome beat for each request, in order, via the stage and output
// registers. A request is decided in a single pass from a stage register
// holding the request and the subject's history, read at acceptance from a
// history memory with one read and one write port. A grant written back in the
// same cycle that the next request for the same subject is read is forwarded
// into that request's history, so back-to-back requests to one subject see each
// other. A start beat clears every subject's history at once through a row of
// per-subject valid bits; an entry whose bit is clear reads as empty, so there
// is no clearing pass after reset or start. The two map registers are to be
// written through the cfg port only while the block is idle; the block does
// not enforce it. Reads and writes beyond the configured subject or object
// counts, and command code 3, are refused and leave the history untouched.
module chinese_wall_access_checker_unit #(
  parameter int unsigned NUM_SUBJECTS = cwac_pkg::DEF_NUM_SUBJECTS,
  parameter int unsigned NUM_OBJECTS  = cwac_pkg::DEF_NUM_OBJECTS,
  parameter int unsigned NUM_FIRMS    = cwac_pkg::DEF_NUM_FIRMS,
  parameter int unsigned NUM_CLASSES  = cwac_pkg::DEF_NUM_CLASSES
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [cwac_pkg::CMD_W-1:0]        in_command,
  input  wire logic [cwac_pkg::SUBJ_W-1:0]       in_subject,
  input  wire logic [cwac_pkg::OBJ_W-1:0]        in_object,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [cwac_pkg::OUTCOME_W-1:0]         out_outcome,
  input  wire logic                              cfg_wr_en,
  input  wire logic [cwac_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [cwac_pkg::MAP_W-1:0]        cfg_data
);
  import cwac_pkg::*;

  // Address bits of the history memory; the subject field is zero-extended first
  // so that the slice stays legal when SIDX_W exceeds the subject width.
  localparam int unsigned SIDX_W = (NUM_SUBJECTS > 1) ? $clog2(NUM_SUBJECTS) : 1;

  logic [MAP_W-1:0] object_firm_map_r;
  logic [MAP_W-1:0] firm_class_map_r;

  // Stage register: the request under decision.
  logic              s1_valid_r;
  logic [CMD_W-1:0]  s1_cmd_r;
  logic [SUBJ_W-1:0] s1_subj_r;
  logic [OBJ_W-1:0]  s1_obj_r;
  logic [SIDX_W-1:0] s1_addr_r;

  // History storage and its forwarding path.
  hist_t             hist_mem [NUM_SUBJECTS];
  hist_t             mem_q_r;
  logic [NUM_SUBJECTS-1:0] hist_vld_r;
  logic              byp_r;
  hist_t             byp_hist_r;

  logic              out_valid_r;
  outcome_t          out_outcome_r;

  logic [SIDX_W+SUBJ_W-1:0] subj_ext;
  logic [SIDX_W-1:0] in_addr;
  logic              in_accept;
  logic              s1_adv;
  logic              s1_commit;
  logic              s1_valid_nxt;
  hist_t             s1_hist;
  decision_t         dec;

  assign subj_ext = {{SIDX_W{1'b0}}, in_subject};
  assign in_addr  = subj_ext[SIDX_W-1:0];

  // The stage moves on when the output register is empty or being drained.
  assign s1_adv    = !out_valid_r || out_ready;
  assign s1_commit = s1_valid_r && s1_adv;
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_accept = in_valid && in_ready;

  // History seen by the request: a forwarded grant wins, then a valid entry,
  // and an entry not written since the last start is empty.
  always_comb begin
    if (byp_r) begin
      s1_hist = byp_hist_r;
    end else if (hist_vld_r[s1_addr_r]) begin
      s1_hist = mem_q_r;
    end else begin
      s1_hist = '0;
    end
  end

  cwac_decide #(
    .NUM_SUBJECTS (NUM_SUBJECTS),
    .NUM_OBJECTS  (NUM_OBJECTS),
    .NUM_FIRMS    (NUM_FIRMS),
    .NUM_CLASSES  (NUM_CLASSES)
  ) u_decide (
    .command         (s1_cmd_r),
    .subject         (s1_subj_r),
    .object_idx      (s1_obj_r),
    .object_firm_map (object_firm_map_r),
    .firm_class_map  (firm_class_map_r),
    .hist            (s1_hist),
    .dec             (dec)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      object_firm_map_r <= '1;
      firm_class_map_r  <= '1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_OBJECT_FIRM_MAP: object_firm_map_r <= cfg_data;
        REG_FIRM_CLASS_MAP:  firm_class_map_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_commit) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Control state: stage and output valid flags and the per-subject valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hist_vld_r  <= '0;
      byp_r       <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_commit && dec.clear) begin
        hist_vld_r <= '0;
      end else if (s1_commit && dec.wr) begin
        hist_vld_r[s1_addr_r] <= 1'b1;
      end
      if (in_accept) begin
        byp_r <= s1_commit && dec.wr && (s1_addr_r == in_addr);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd_r   <= in_command;
      s1_subj_r  <= in_subject;
      s1_obj_r   <= in_object;
      s1_addr_r  <= in_addr;
      byp_hist_r <= dec.hist;
    end
    if (s1_commit) begin
      out_outcome_r <= dec.outcome;
    end
  end

  // History memory: one registered read at acceptance, a write at each grant.
  always_ff @(posedge clk) begin
    if (s1_commit && dec.wr) begin
      hist_mem[s1_addr_r] <= dec.hist;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mem_q_r <= hist_mem[in_addr];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_outcome = out_outcome_r;

endmodule

`default_nettype wire

FILE: sv/cwac_decide.sv
// Combinational access decision for one request against one subject's history.
// Depends on cwac_pkg for codes, history types and map decoding.
`default_nettype none

module cwac_decide #(
  parameter int unsigned NUM_SUBJECTS = cwac_pkg::DEF_NUM_SUBJECTS,
  parameter int unsigned NUM_OBJECTS  = cwac_pkg::DEF_NUM_OBJECTS,
  parameter int unsigned NUM_FIRMS    = cwac_pkg::DEF_NUM_FIRMS,
  parameter int unsigned NUM_CLASSES  = cwac_pkg::DEF_NUM_CLASSES
) (
  input  wire logic [cwac_pkg::CMD_W-1:0]  command,
  input  wire logic [cwac_pkg::SUBJ_W-1:0] subject,
  input  wire logic [cwac_pkg::OBJ_W-1:0]  object_idx,
  input  wire logic [cwac_pkg::MAP_W-1:0]  object_firm_map,
  input  wire logic [cwac_pkg::MAP_W-1:0]  firm_class_map,
  input  wire cwac_pkg::hist_t             hist,
  output cwac_pkg::decision_t              dec
);
  import cwac_pkg::*;

  code_t   firm;
  code_t   cls;
  code_t   cls_f [BITMAP_W];
  logic    touched;
  logic    conflict;
  logic    in_range;
  logic    may_read;
  logic    may_write;
  bitmap_t firm_bit;

  always_comb begin
    firm = map_code(object_firm_map, object_idx, NUM_FIRMS);
    cls  = (firm == NONE_CODE) ? NONE_CODE : map_code(firm_class_map, firm[2:0], NUM_CLASSES);
    firm_bit = bitmap_t'(1) << firm;

    // Class of every firm the bitmaps can hold, the none firm last.
    touched  = 1'b0;
    conflict = 1'b0;
    for (int f = 0; f < BITMAP_W; f++) begin
      cls_f[f] = (f == BITMAP_W - 1) ? NONE_CODE
                 : map_code(firm_class_map, 3'(f), NUM_CLASSES);
      if (hist.acc[f] && cls_f[f] == cls) begin
        touched = 1'b1;
      end
      if (hist.rd[f] && code_t'(f) != firm && cls_f[f] == cls) begin
        conflict = 1'b1;
      end
    end

    in_range  = (32'(subject) < NUM_SUBJECTS) && (32'(object_idx) < NUM_OBJECTS);
    may_read  = !touched || hist.acc[firm];
    may_write = may_read && !conflict;

    dec.wr       = 1'b0;
    dec.clear    = 1'b0;
    dec.hist.acc = hist.acc | firm_bit;
    dec.hist.rd  = hist.rd;
    dec.outcome  = OUT_REFUSED;

    unique case (command)
      CMD_START: begin
        dec.clear   = 1'b1;
        dec.outcome = OUT_CLEARED;
      end
      CMD_READ: begin
        if (in_range && may_read) begin
          dec.wr      = 1'b1;
          dec.hist.rd = hist.rd | firm_bit;
          dec.outcome = OUT_ACCEPTED;
        end
      end
      CMD_WRITE: begin
        if (in_range && may_write) begin
          dec.wr      = 1'b1;
          dec.outcome = OUT_ACCEPTED;
        end
      end
      default: begin
        dec.outcome = OUT_REFUSED;
      end
    endcase
  end

endmodule

`default_nettype wire
